### rtl/ordl_pkg.sv
// Shared constants, request and status codes, and the controller/datapath
// command and status structs for the ordered ID list block. No dependencies.
package ordl_pkg;

   localparam int REF_DEPTH  = 1024;
   localparam int LIST_DEPTH = 64;
   localparam int ID_BITS    = 24;

   localparam int REF_AW  = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
   localparam int LIST_AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int REF_CW  = $clog2(REF_DEPTH + 1);
   localparam int LIST_CW = $clog2(LIST_DEPTH + 1);
   localparam int WALK_W  = (REF_CW > LIST_CW) ? REF_CW : LIST_CW;

   localparam int TYPE_BITS   = 2;
   localparam int STATUS_BITS = 3;
   localparam int SIZE_BITS   = 7;

   localparam logic [TYPE_BITS-1:0] REQ_LOAD   = 2'd0;
   localparam logic [TYPE_BITS-1:0] REQ_ADD    = 2'd1;
   localparam logic [TYPE_BITS-1:0] REQ_REMOVE = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_ADDED      = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_ALREADY    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_UNKNOWN    = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL       = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_REMOVED    = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_NOT_LISTED = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_LOADED     = 3'd6;
   localparam logic [STATUS_BITS-1:0] ST_TABLE_FULL = 3'd7;

   typedef struct packed {
      logic                   capture;
      logic                   ref_write;
      logic                   walk_start;
      logic                   walk_table;
      logic                   walk_from_hit;
      logic                   walk_step;
      logic                   shift_write;
      logic                   list_append;
      logic                   list_drop;
      logic                   set_status;
      logic [STATUS_BITS-1:0] status;
      logic                   rsp_load;
   } ordl_cmd_type;

   typedef struct packed {
      logic [TYPE_BITS-1:0] kind;
      logic                 ref_full;
      logic                 list_full;
      logic                 hit;
      logic                 walk_done;
      logic                 rsp_busy;
   } ordl_stat_type;

endpackage

### rtl/ordl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ordl_ram #(
   parameter int   WIDTH = 8,
   parameter int   DEPTH = 16,
   localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ordl_ctrl.sv
// Controller state machine for the ordered ID list block.
// Depends on ordl_pkg; drives ordl_dp through command and status structs.
module ordl_ctrl
   import ordl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ordl_stat_type stat,
   output ordl_cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_LSCAN  = 6'b000100,
      S_TSCAN  = 6'b001000,
      S_SHIFT  = 6'b010000,
      S_REPLY  = 6'b100000
   } ordl_state_type;

   ordl_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.kind)
               REQ_LOAD: begin
                  cmd.set_status = 1'b1;
                  if (stat.ref_full) begin
                     cmd.status = ST_TABLE_FULL;
                  end else begin
                     cmd.ref_write = 1'b1;
                     cmd.status    = ST_LOADED;
                  end
                  state_in = S_REPLY;
               end
               REQ_ADD, REQ_REMOVE: begin
                  cmd.walk_start = 1'b1;
                  state_in       = S_LSCAN;
               end
               default: begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_UNKNOWN;
                  state_in       = S_REPLY;
               end
            endcase
         end
         S_LSCAN: begin
            cmd.walk_step = 1'b1;
            if (stat.hit) begin
               if (stat.kind == REQ_ADD) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_ALREADY;
                  state_in       = S_REPLY;
               end else begin
                  cmd.walk_start    = 1'b1;
                  cmd.walk_from_hit = 1'b1;
                  state_in          = S_SHIFT;
               end
            end else if (stat.walk_done) begin
               if (stat.kind == REQ_ADD) begin
                  cmd.walk_start = 1'b1;
                  cmd.walk_table = 1'b1;
                  state_in       = S_TSCAN;
               end else begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_NOT_LISTED;
                  state_in       = S_REPLY;
               end
            end
         end
         S_TSCAN: begin
            cmd.walk_step = 1'b1;
            if (stat.hit) begin
               cmd.set_status = 1'b1;
               if (stat.list_full) begin
                  cmd.status = ST_FULL;
               end else begin
                  cmd.list_append = 1'b1;
                  cmd.status      = ST_ADDED;
               end
               state_in = S_REPLY;
            end else if (stat.walk_done) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_UNKNOWN;
               state_in       = S_REPLY;
            end
         end
         S_SHIFT: begin
            cmd.walk_step   = 1'b1;
            cmd.shift_write = 1'b1;
            if (stat.walk_done) begin
               cmd.list_drop  = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = ST_REMOVED;
               state_in       = S_REPLY;
            end
         end
         S_REPLY: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/ordl_dp.sv
// Datapath for the ordered ID list block: request registers, counts, walk
// counter, reference and list RAMs, result register. Depends on ordl_pkg, ordl_ram.
module ordl_dp
   import ordl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [TYPE_BITS-1:0]   req_type,
   input  logic [ID_BITS-1:0]     req_item_id,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [SIZE_BITS-1:0]   rsp_list_size,
   input  ordl_cmd_type           cmd,
   output ordl_stat_type          stat
);

   logic [ID_BITS-1:0]     id_ff;
   logic [TYPE_BITS-1:0]   kind_ff;
   logic [REF_CW-1:0]      ref_count_ff, ref_count_in;
   logic [LIST_CW-1:0]     list_len_ff, list_len_in;
   logic [WALK_W-1:0]      walk_ix_ff, walk_ix_in;
   logic                   walk_sel_ff, walk_sel_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [WALK_W-1:0]      cmp_ix_ff, cmp_ix_in;
   logic [STATUS_BITS-1:0] status_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [SIZE_BITS-1:0]   rsp_size_ff;

   logic [WALK_W-1:0]  walk_limit;
   logic               walk_more;
   logic [ID_BITS-1:0] ref_rd, list_rd, walk_rd;
   logic [WALK_W-1:0]  shift_ix;
   logic               list_we;
   logic [LIST_AW-1:0] list_wa;
   logic [ID_BITS-1:0] list_wd;

   assign walk_limit = walk_sel_ff ? WALK_W'(ref_count_ff) : WALK_W'(list_len_ff);
   assign walk_more  = walk_ix_ff < walk_limit;
   assign walk_rd    = walk_sel_ff ? ref_rd : list_rd;
   assign shift_ix   = cmp_ix_ff - WALK_W'(1);

   assign list_we = cmd.list_append || (cmd.shift_write && cmp_vld_ff);
   assign list_wa = cmd.list_append ? list_len_ff[LIST_AW-1:0] : shift_ix[LIST_AW-1:0];
   assign list_wd = cmd.list_append ? id_ff : list_rd;

   ordl_ram #(.WIDTH(ID_BITS), .DEPTH(REF_DEPTH)) u_ref_ram (
      .clock   (clock),
      .wr_en   (cmd.ref_write),
      .wr_addr (ref_count_ff[REF_AW-1:0]),
      .wr_data (id_ff),
      .rd_addr (walk_ix_ff[REF_AW-1:0]),
      .rd_data (ref_rd)
   );

   ordl_ram #(.WIDTH(ID_BITS), .DEPTH(LIST_DEPTH)) u_list_ram (
      .clock   (clock),
      .wr_en   (list_we),
      .wr_addr (list_wa),
      .wr_data (list_wd),
      .rd_addr (walk_ix_ff[LIST_AW-1:0]),
      .rd_data (list_rd)
   );

   always_comb begin
      walk_ix_in  = walk_ix_ff;
      walk_sel_in = walk_sel_ff;
      cmp_vld_in  = cmp_vld_ff;
      cmp_ix_in   = cmp_ix_ff;
      if (cmd.walk_start) begin
         walk_ix_in  = cmd.walk_from_hit ? (cmp_ix_ff + WALK_W'(1)) : '0;
         walk_sel_in = cmd.walk_table;
         cmp_vld_in  = 1'b0;
      end else if (cmd.walk_step) begin
         cmp_vld_in = walk_more;
         cmp_ix_in  = walk_ix_ff;
         if (walk_more) begin
            walk_ix_in = walk_ix_ff + WALK_W'(1);
         end
      end
   end

   always_comb begin
      ref_count_in = ref_count_ff;
      list_len_in  = list_len_ff;
      if (cmd.ref_write) begin
         ref_count_in = ref_count_ff + REF_CW'(1);
      end
      if (cmd.list_append) begin
         list_len_in = list_len_ff + LIST_CW'(1);
      end else if (cmd.list_drop) begin
         list_len_in = list_len_ff - LIST_CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_count_ff <= '0;
         list_len_ff  <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ref_count_ff <= ref_count_in;
         list_len_ff  <= list_len_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ix_ff  <= walk_ix_in;
      walk_sel_ff <= walk_sel_in;
      cmp_ix_ff   <= cmp_ix_in;
      if (cmd.capture) begin
         id_ff   <= req_item_id;
         kind_ff <= req_type;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_size_ff   <= SIZE_BITS'(list_len_ff);
      end
   end

   assign stat.kind      = kind_ff;
   assign stat.ref_full  = ref_count_ff == REF_CW'(REF_DEPTH);
   assign stat.list_full = list_len_ff == LIST_CW'(LIST_DEPTH);
   assign stat.hit       = cmp_vld_ff && (walk_rd == id_ff);
   assign stat.walk_done = !cmp_vld_ff && !walk_more;
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_list_size = rsp_size_ff;

endmodule

### rtl/ordered_id_list_with_membership.sv
// Top level of the ordered ID list block: controller plus datapath.
// Depends on ordl_pkg, ordl_ctrl, ordl_dp.
//
// Request channel (req_valid/req_ready, req_type, req_item_id): a load appends
// the ID to the reference table, an add lists a known, unlisted ID at the end,
// a remove deletes a listed ID and moves later entries down in order.
// Response channel (rsp_valid/rsp_ready, rsp_status, rsp_list_size): exactly
// one response per request, in request order.
// One request is worked at a time; req_ready is high only while idle.
// Work from acceptance to response valid:
//   load, or unused type:  decode, then reply
//   add:    list search, then a reference table search if not listed, then reply
//   remove: list search plus the shift of later entries, then reply
// The walk counter reads one entry per cycle from the single read port of the
// reference RAM or the list RAM during each search and shift. The next request
// can be taken in the same cycle that the response goes valid.
// The response sits in an output register; the next request is taken while it
// waits. A stalled receiver holds the response and, once the following request
// is done, holds the block in its reply state until the response is taken.
// Reset clears both counts and the response valid; no clearing pass is needed.
module ordered_id_list_with_membership
   import ordl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [TYPE_BITS-1:0]   req_type,
   input  logic [ID_BITS-1:0]     req_item_id,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [SIZE_BITS-1:0]   rsp_list_size
);

   ordl_cmd_type  cmd;
   ordl_stat_type stat;

   ordl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ordl_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_type      (req_type),
      .req_item_id   (req_item_id),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_list_size (rsp_list_size),
      .cmd           (cmd),
      .stat          (stat)
   );

endmodule

### rtl/ordl_chk.sv
// Port-level checker for the ordered ID list block, bound to the top level.
// Depends on ordl_pkg and ordered_id_list_with_membership.
module ordl_chk
   import ordl_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STATUS_BITS-1:0] rsp_status,
   input logic [SIZE_BITS-1:0]   rsp_list_size
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_list_size))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   a_size_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_list_size <= SIZE_BITS'(LIST_DEPTH))
      else $error("list size beyond capacity");

   a_full_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_list_size == SIZE_BITS'(LIST_DEPTH))
      else $error("list full reported below capacity");

endmodule

bind ordered_id_list_with_membership ordl_chk u_ordl_chk (.*);

### bench/tb.sv
`timescale 1ns / 1ps
// Testbench for ordered_id_list_with_membership: directed and random load, add,
// remove and unused-type requests, each response checked against a behavioral
// table and list. Depends on ordl_pkg and the block's RTL.
module tb
   import ordl_pkg::*;
();

   localparam logic [TYPE_BITS-1:0] REQ_UNUSED = 2'd3;
   localparam int     RANDOM_ITEMS = 400;
   localparam longint CYCLE_LIMIT  = 8_000_000;
   localparam int     TAIL_CYCLES  = 1200;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [SIZE_BITS-1:0]   count;
   } list_reply_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [TYPE_BITS-1:0]   req_type;
   logic [ID_BITS-1:0]     req_item_id;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [SIZE_BITS-1:0]   rsp_list_size;

   logic [ID_BITS-1:0] known_q[$];
   logic [ID_BITS-1:0] picked_q[$];
   list_reply_type     reply_q[$];
   int                 errors    = 0;
   longint             cycle_cnt = 0;
   bit                 idle_on   = 1'b1;
   bit                 stall_on  = 1'b1;

   ordered_id_list_with_membership i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_item_id   (req_item_id),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_list_size (rsp_list_size)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (errors < 100)
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   function automatic int find_picked(input logic [ID_BITS-1:0] id);
      for (int i = 0; i < picked_q.size(); i++)
         if (picked_q[i] == id)
            return i;
      return -1;
   endfunction

   function automatic list_reply_type apply_request(input logic [TYPE_BITS-1:0] kind,
                                                    input logic [ID_BITS-1:0] id);
      list_reply_type r;
      int             pos;
      bit             known;
      pos   = find_picked(id);
      known = 1'b0;
      foreach (known_q[i])
         if (known_q[i] == id)
            known = 1'b1;
      case (kind)
         REQ_LOAD: begin
            if (known_q.size() >= REF_DEPTH) begin
               r.status = ST_TABLE_FULL;
            end else begin
               known_q.push_back(id);
               r.status = ST_LOADED;
            end
         end
         REQ_ADD: begin
            if (pos >= 0) begin
               r.status = ST_ALREADY;
            end else if (!known) begin
               r.status = ST_UNKNOWN;
            end else if (picked_q.size() >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               picked_q.push_back(id);
               r.status = ST_ADDED;
            end
         end
         REQ_REMOVE: begin
            if (pos >= 0) begin
               picked_q.delete(pos);
               r.status = ST_REMOVED;
            end else begin
               r.status = ST_NOT_LISTED;
            end
         end
         default: begin
            r.status = ST_UNKNOWN;
         end
      endcase
      r.count = SIZE_BITS'(picked_q.size());
      return r;
   endfunction

   function automatic logic [ID_BITS-1:0] rand_id();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return r[ID_BITS-1:0];
      endcase
   endfunction

   function automatic logic [ID_BITS-1:0] any_known();
      if (known_q.size() == 0)
         return rand_id();
      return known_q[$urandom_range(0, known_q.size() - 1)];
   endfunction

   function automatic logic [ID_BITS-1:0] any_picked();
      if (picked_q.size() == 0)
         return rand_id();
      return picked_q[$urandom_range(0, picked_q.size() - 1)];
   endfunction

   function automatic logic [ID_BITS-1:0] unlisted_known();
      for (int i = known_q.size() - 1; i >= 0; i--)
         if (find_picked(known_q[i]) < 0)
            return known_q[i];
      return rand_id();
   endfunction

   task automatic send_request(input logic [TYPE_BITS-1:0] kind,
                               input logic [ID_BITS-1:0] id);
      int gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_item_id <= id;
      do @(posedge clock); while (req_ready !== 1'b1);
      reply_q.push_back(apply_request(kind, id));
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      while (reply_q.size() != 0) @(posedge clock);
   endtask

   task automatic fill_list();
      for (int i = known_q.size() - 1; i >= 0 && picked_q.size() < LIST_DEPTH; i--)
         if (find_picked(known_q[i]) < 0)
            send_request(REQ_ADD, known_q[i]);
   endtask

   // while stall_on is set, hold rsp_ready low for a random stall before each response
   initial begin
      int stall;
      forever begin
         stall = stall_on ? $urandom_range(0, 9) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (reset !== 1'b0 || rsp_valid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      list_reply_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (reply_q.size() == 0) begin
            report_mismatch("response with no request waiting", rsp_status, 0);
         end else begin
            want = reply_q.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_list_size !== want.count)
               report_mismatch("list size", rsp_list_size, want.count);
         end
      end
   end

   task automatic test_directed();
      send_request(REQ_ADD, 24'h000000);
      send_request(REQ_REMOVE, 24'h000000);
      send_request(REQ_UNUSED, 24'hFFFFFF);
      send_request(REQ_LOAD, 24'h000000);
      send_request(REQ_LOAD, 24'hFFFFFF);
      send_request(REQ_LOAD, 24'hFFFFFF);
      send_request(REQ_LOAD, 24'h555555);
      send_request(REQ_LOAD, 24'hAAAAAA);
      send_request(REQ_ADD, 24'hFFFFFF);
      send_request(REQ_ADD, 24'hFFFFFF);
      send_request(REQ_ADD, 24'h000000);
      send_request(REQ_ADD, 24'h123456);
      send_request(REQ_ADD, 24'h555555);
      send_request(REQ_ADD, 24'hAAAAAA);
      send_request(REQ_REMOVE, 24'h000000);
      send_request(REQ_REMOVE, 24'hAAAAAA);
      send_request(REQ_REMOVE, 24'hFFFFFF);
      send_request(REQ_REMOVE, 24'hFFFFFF);
      send_request(REQ_UNUSED, 24'h000000);
      send_request(REQ_ADD, 24'h000000);
      send_request(REQ_REMOVE, 24'h555555);
      send_request(REQ_REMOVE, 24'h000000);
      send_request(REQ_ADD, 24'hFFFFFF);
      drain_replies();
   endtask

   task automatic test_random_mix();
      int                   pick;
      int                   sub;
      logic [TYPE_BITS-1:0] kind;
      logic [ID_BITS-1:0]   id;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            idle_on  = ($urandom_range(0, 2) != 0);
            stall_on = ($urandom_range(0, 2) != 0);
         end
         pick = $urandom_range(0, 99);
         sub  = $urandom_range(0, 9);
         if (pick < 12 && known_q.size() < 160) begin
            kind = REQ_LOAD;
            id   = (sub < 2) ? any_known() : rand_id();
         end else if (pick < 60) begin
            kind = REQ_ADD;
            id   = (sub < 7) ? any_known() : (sub < 9) ? any_picked() : rand_id();
         end else if (pick < 95) begin
            kind = REQ_REMOVE;
            id   = (sub < 7) ? any_picked() : (sub < 8) ? any_known() : rand_id();
         end else begin
            kind = REQ_UNUSED;
            id   = rand_id();
         end
         send_request(kind, id);
      end
      drain_replies();
   endtask

   task automatic test_list_full();
      idle_on  = 1'b1;
      stall_on = 1'b1;
      repeat (LIST_DEPTH + 4) send_request(REQ_LOAD, rand_id());
      fill_list();
      send_request(REQ_ADD, unlisted_known());
      send_request(REQ_ADD, any_picked());
      send_request(REQ_ADD, rand_id());
      send_request(REQ_REMOVE, picked_q[0]);
      send_request(REQ_REMOVE, picked_q[picked_q.size() - 1]);
      send_request(REQ_REMOVE, picked_q[picked_q.size() / 2]);
      send_request(REQ_ADD, unlisted_known());
      send_request(REQ_REMOVE, rand_id());
      drain_replies();
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_type    <= REQ_LOAD;
      req_item_id <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix();
      test_list_full();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && reply_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### ordered_id_list_with_membership.f
rtl/ordl_pkg.sv
rtl/ordl_ram.sv
rtl/ordl_ctrl.sv
rtl/ordl_dp.sv
rtl/ordered_id_list_with_membership.sv
rtl/ordl_chk.sv
bench/tb.sv
